FILE: src/zdc_pkg.sv
// package: shared types, constants and zigzag helper functions
`timescale 1ns / 1ps
package zdc_pkg;

  localparam int DATA_W         = 32;
  localparam int WIDTH_W        = 6;
  localparam int CFG_IDX_W      = 8;
  localparam int CFG_DATA_W     = 32;
  localparam int VALUE_BITS_DEF = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE        = 8'd0,
    CFG_VALUE_WIDTH = 8'd1,
    CFG_DELTA_WIDTH = 8'd2
  } cfg_idx_t;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic [WIDTH_W-1:0] value_width;
    logic [WIDTH_W-1:0] delta_width;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic [DATA_W-1:0]        code_in;
    logic                     first;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0]        code_out;
    logic [WIDTH_W-1:0]       code_width;
    logic signed [DATA_W-1:0] value_out;
    logic [WIDTH_W-1:0]       peak_width;
    logic                     width_exceeded;
  } result_t;

  function automatic logic [DATA_W-1:0] zz_encode(input logic [DATA_W-1:0] v);
    return {v[DATA_W-2:0], 1'b0} ^ {DATA_W{v[DATA_W-1]}};
  endfunction

  function automatic logic [DATA_W-1:0] zz_decode(input logic [DATA_W-1:0] c);
    return {1'b0, c[DATA_W-1:1]} ^ {DATA_W{c[0]}};
  endfunction

  function automatic logic [DATA_W-1:0] width_mask(input logic [WIDTH_W-1:0] w);
    if (w >= WIDTH_W'(DATA_W)) return {DATA_W{1'b1}};
    return ~({DATA_W{1'b1}} << w);
  endfunction

  // position of the highest set bit plus one, zero for zero
  function automatic logic [WIDTH_W-1:0] bit_length(input logic [DATA_W-1:0] v);
    logic [WIDTH_W-1:0] n;
    n = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (v[i]) n = WIDTH_W'(i + 1);
    end
    return n;
  endfunction

endpackage

FILE: src/zdc_if.sv
// interfaces: input, result and configuration channels
`timescale 1ns / 1ps
interface zdc_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [zdc_pkg::DATA_W-1:0] sample;
  logic [zdc_pkg::DATA_W-1:0]        code_in;
  logic                              first;

  modport source (output valid, output sample, output code_in, output first, input ready);
  modport sink (input valid, input sample, input code_in, input first, output ready);
endinterface

interface zdc_out_if;
  logic                              valid;
  logic                              ready;
  logic [zdc_pkg::DATA_W-1:0]        code_out;
  logic [zdc_pkg::WIDTH_W-1:0]       code_width;
  logic signed [zdc_pkg::DATA_W-1:0] value_out;
  logic [zdc_pkg::WIDTH_W-1:0]       peak_width;
  logic                              width_exceeded;

  modport source (output valid, output code_out, output code_width, output value_out,
                  output peak_width, output width_exceeded, input ready);
  modport sink (input valid, input code_out, input code_width, input value_out,
                input peak_width, input width_exceeded, output ready);
endinterface

interface zdc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [zdc_pkg::CFG_IDX_W-1:0]    index;
  logic [zdc_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/zdc_in_stage.sv
// input register: holds one accepted item for the datapath
`timescale 1ns / 1ps
module zdc_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  zdc_pkg::item_t in_item,
  output logic           in_ready,
  input  logic           advance,
  output logic           item_valid,
  output zdc_pkg::item_t item
);

  logic           valid_r;
  logic           valid_nxt;
  zdc_pkg::item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

FILE: src/zdc_datapath.sv
// zigzag delta datapath with previous value and peak length state
`timescale 1ns / 1ps
module zdc_datapath #(
  parameter int VALUE_BITS = zdc_pkg::VALUE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  zdc_pkg::cfg_t    cfg,
  input  zdc_pkg::item_t   item,
  input  logic             fire,
  output logic             emit,
  output zdc_pkg::result_t result
);

  localparam logic [zdc_pkg::WIDTH_W-1:0] VB = zdc_pkg::WIDTH_W'(VALUE_BITS);

  logic [zdc_pkg::DATA_W-1:0]  prev_r;
  logic [zdc_pkg::DATA_W-1:0]  prev_nxt;
  logic [zdc_pkg::WIDTH_W-1:0] peak_r;
  logic [zdc_pkg::WIDTH_W-1:0] peak_nxt;
  logic [zdc_pkg::WIDTH_W-1:0] vw;
  logic [zdc_pkg::WIDTH_W-1:0] dw;
  logic [zdc_pkg::DATA_W-1:0]  zz_delta;
  logic [zdc_pkg::DATA_W-1:0]  len_src;
  logic [zdc_pkg::WIDTH_W-1:0] len;
  logic [zdc_pkg::WIDTH_W-1:0] len_kept;
  logic [zdc_pkg::DATA_W-1:0]  vw_code;
  logic [zdc_pkg::DATA_W-1:0]  dw_code;
  logic                        is_enc;

  assign vw     = (cfg.value_width > VB) ? VB : cfg.value_width;
  assign dw     = (cfg.delta_width > VB) ? VB : cfg.delta_width;
  assign is_enc = (cfg.mode == zdc_pkg::MODE_ENCODE);

  assign zz_delta = zdc_pkg::zz_encode(item.sample - prev_r);
  // one priority encoder serves both modes
  assign len_src  = is_enc ? zz_delta : item.code_in;
  assign len      = zdc_pkg::bit_length(len_src);

  assign vw_code = (is_enc ? zdc_pkg::zz_encode(item.sample) : item.code_in)
                   & zdc_pkg::width_mask(vw);
  assign dw_code = (is_enc ? zz_delta : item.code_in) & zdc_pkg::width_mask(dw);

  // bit length after masking to dw bits
  assign len_kept = zdc_pkg::bit_length(dw_code);

  always_comb begin
    prev_nxt              = prev_r;
    peak_nxt              = peak_r;
    emit                  = 1'b1;
    result.code_out       = '0;
    result.code_width     = '0;
    result.value_out      = '0;
    result.width_exceeded = 1'b0;
    if (item.first) begin
      peak_nxt          = '0;
      result.code_width = vw;
      result.code_out   = vw_code;
      result.value_out  = is_enc ? item.sample : zdc_pkg::zz_decode(vw_code);
      prev_nxt          = result.value_out;
    end else if (is_enc) begin
      if (len > peak_r) peak_nxt = len;
      prev_nxt              = item.sample;
      emit                  = (dw != '0);
      result.width_exceeded = (len > dw);
      result.code_out       = dw_code;
      result.code_width     = dw;
      result.value_out      = item.sample;
    end else begin
      result.width_exceeded = (len > dw);
      if (dw == '0) begin
        if (len > peak_r) peak_nxt = len;
        result.value_out = prev_r;
      end else begin
        if (len_kept > peak_r) peak_nxt = len_kept;
        result.code_out   = dw_code;
        result.code_width = dw;
        result.value_out  = prev_r + zdc_pkg::zz_decode(dw_code);
        prev_nxt          = result.value_out;
      end
    end
    result.peak_width = peak_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      peak_r <= '0;
    end else if (fire) begin
      prev_r <= prev_nxt;
      peak_r <= peak_nxt;
    end
  end

`ifndef SYNTHESIS
  a_first_clears_peak: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.first |=> peak_r == '0)
    else $error("peak not cleared by first element");

  a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !item.first |=> peak_r >= $past(peak_r))
    else $error("peak length decreased within an array");

  a_enc_tracks_sample: assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_enc |=> prev_r == $past(item.sample))
    else $error("encode did not keep the sample as previous value");
`endif

endmodule

FILE: src/zdc_out_stage.sv
// result register: holds one result until the sink takes it
`timescale 1ns / 1ps
module zdc_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  zdc_pkg::result_t result_in,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output zdc_pkg::result_t result_out
);

  logic             valid_r;
  logic             valid_nxt;
  zdc_pkg::result_t result_r;

  assign free       = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign result_out = result_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result_in;
    end
  end

endmodule

FILE: src/zigzag_delta_codec_core.sv
// top level: zigzag delta encoder/decoder with configuration registers
`timescale 1ns / 1ps
// Usage:
//  in_ch  takes one element per transfer: sample (encode), code_in (decode), first.
//  out_ch gives at most one result per element: code_out, code_width,
//         value_out, peak_width, width_exceeded. In encode mode a later element
//         gives no result when delta_width is 0.
//  cfg_ch writes mode (index 0), value_width (1), delta_width (2); other
//         indexes are ignored. Always ready; write only while the block is idle.
// Timing:
//  an accepted element sits in the input register, goes through the single
//  subtract / zigzag / leading-one / mask path and lands in the result
//  register once that register is free. One element per cycle is sustained
//  while out_ch accepts the results; the loop through the previous value and
//  peak registers closes within that combinational path.
// Reset (rst_n low, synchronous): both stages empty, mode encode, widths 32,
//  previous value and peak length zero.
// Stall: while out_ch is held off the result register keeps its item and the
//  input register takes one more; if that item has a result, in_ch.ready then
//  drops until the sink frees the result register.
module zigzag_delta_codec_core #(
  parameter int VALUE_BITS = zdc_pkg::VALUE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  zdc_in_if.sink    in_ch,
  zdc_out_if.source out_ch,
  zdc_cfg_if.sink   cfg_ch
);

  zdc_pkg::cfg_t    cfg_r;
  zdc_pkg::item_t   in_item;
  zdc_pkg::item_t   item;
  zdc_pkg::result_t result;
  zdc_pkg::result_t result_q;
  logic             item_valid;
  logic             emit;
  logic             free;
  logic             advance;
  logic             load;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode        <= zdc_pkg::MODE_ENCODE;
      cfg_r.value_width <= zdc_pkg::WIDTH_W'(zdc_pkg::DATA_W);
      cfg_r.delta_width <= zdc_pkg::WIDTH_W'(zdc_pkg::DATA_W);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        zdc_pkg::CFG_MODE:        cfg_r.mode <= zdc_pkg::mode_t'(cfg_ch.data[0]);
        zdc_pkg::CFG_VALUE_WIDTH: cfg_r.value_width <= cfg_ch.data[zdc_pkg::WIDTH_W-1:0];
        zdc_pkg::CFG_DELTA_WIDTH: cfg_r.delta_width <= cfg_ch.data[zdc_pkg::WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_item.sample  = in_ch.sample;
  assign in_item.code_in = in_ch.code_in;
  assign in_item.first   = in_ch.first;

  // an item without a result moves on even while the result register is full
  assign advance = item_valid && (!emit || free);
  assign load    = advance && emit;

  zdc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_item    (in_item),
    .in_ready   (in_ch.ready),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  zdc_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .item   (item),
    .fire   (advance),
    .emit   (emit),
    .result (result)
  );

  zdc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .result_in  (result),
    .free       (free),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .result_out (result_q)
  );

  assign out_ch.code_out       = result_q.code_out;
  assign out_ch.code_width     = result_q.code_width;
  assign out_ch.value_out      = result_q.value_out;
  assign out_ch.peak_width     = result_q.peak_width;
  assign out_ch.width_exceeded = result_q.width_exceeded;

`ifndef SYNTHESIS
  a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_ch.valid || out_ch.ready))
    else $error("result register overwritten while held");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_ch.valid)
    else $error("emitted result not presented");

  a_silent_only_encode: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && !emit |-> cfg_r.mode == zdc_pkg::MODE_ENCODE && !item.first)
    else $error("item dropped outside encode with zero delta width");
`endif

endmodule
